>>> rtl/srdg_pkg.sv
// shared types and constants of the stepper ramp delay generator
package srdg_pkg;

   localparam int unsigned MaxSteps = 1023;

   localparam int unsigned DivWidth = 19;
   localparam int unsigned RemWidth = 18;
   localparam int unsigned CntWidth = $clog2(DivWidth + 1);

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_NEXT  = 1'b1;

   localparam logic [15:0] FIRST_DELAY_RESET = 16'd10000;
   localparam logic [15:0] MIN_DELAY_RESET   = 16'd100;
   localparam logic [15:0] K_OFFSET_RESET    = 16'd0;

   typedef enum logic [1:0] {
      CSR_FIRST_DELAY = 2'd0,
      CSR_MIN_DELAY   = 2'd1,
      CSR_K_OFFSET    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DivWidth-1:0] num;
      logic [DivWidth-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DivWidth-1:0] quo;
      logic [DivWidth-1:0] rem;
   } div_res_type;

endpackage

>>> rtl/srdg_ifs.sv
// channel interfaces: request, response and register write
interface srdg_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] step_count;

   modport source (output valid, output kind, output step_count, input ready);
   modport sink (input valid, input kind, input step_count, output ready);
endinterface

interface srdg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] delay;
   logic        last;
   logic        error;

   modport source (output valid, output delay, output last, output error, input ready);
   modport sink (input valid, input delay, input last, input error, output ready);
endinterface

interface srdg_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/srdg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module srdg_div (
   input  logic                clock,
   input  logic                reset,
   input  srdg_pkg::div_req_type div_req,
   output srdg_pkg::div_res_type div_res
);

   logic [srdg_pkg::DivWidth-1:0] acc_ff, acc_in;
   logic [srdg_pkg::DivWidth-1:0] nq_ff, nq_in;
   logic [srdg_pkg::DivWidth-1:0] den_ff, den_in;
   logic [srdg_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [srdg_pkg::DivWidth:0]   shifted;
   logic [srdg_pkg::DivWidth+1:0] trial;
   logic                          fits;

   always_comb begin
      shifted = {acc_ff, nq_ff[srdg_pkg::DivWidth-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~trial[srdg_pkg::DivWidth+1];

      acc_in  = acc_ff;
      nq_in   = nq_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         acc_in  = '0;
         nq_in   = div_req.num;
         den_in  = div_req.den;
         cnt_in  = srdg_pkg::CntWidth'(srdg_pkg::DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the narrow accumulator
         acc_in = fits ? trial[srdg_pkg::DivWidth-1:0] : shifted[srdg_pkg::DivWidth-1:0];
         nq_in  = {nq_ff[srdg_pkg::DivWidth-2:0], fits};
         cnt_in = cnt_ff - srdg_pkg::CntWidth'(1);
         if (cnt_ff == srdg_pkg::CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      nq_ff  <= nq_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_res.done = done_ff;
   assign div_res.quo  = nq_ff;
   assign div_res.rem  = acc_ff;

endmodule

>>> rtl/stepper_ramp_delay_generator_unit.sv
// top level of the stepper ramp delay generator: sequencer, registers and result stage
//
//   port      dir   role                      payload
//   req_bus   sink  start move / next delay   kind, step_count
//   rsp_bus   src   one result per request    delay, last, error
//   csr_bus   sink  register write            index, data
//
// a request with a ramp division passes from the accept through the evaluate state, the
// bit-serial divider (19 quotient bits plus its done register) and the output state; other
// requests go from the evaluate state straight to the output state
// reset clears the move state and loads the registers with their reset values
// a new request is taken while a finished result still waits in the output register;
// the following result stalls until rsp_bus is ready
module stepper_ramp_delay_generator_unit (
   input  logic             clock,
   input  logic             reset,
   srdg_req_if.sink         req_bus,
   srdg_rsp_if.source       rsp_bus,
   srdg_csr_if.sink         csr_bus
);

   srdg_pkg::state_type state_ff, state_in;

   logic [15:0] first_delay_ff, min_delay_ff, k_offset_ff;

   logic [15:0]                   step_index_ff, step_index_in;
   logic [15:0]                   total_steps_ff, total_steps_in;
   logic [15:0]                   prev_delay_ff, prev_delay_in;
   logic [srdg_pkg::RemWidth-1:0] rem_acc_ff, rem_acc_in;
   logic [15:0]                   accel_end_ff, accel_end_in;
   logic [15:0]                   cruise_len_ff, cruise_len_in;
   logic                          move_active_ff, move_active_in;
   logic                          decel_ff, decel_in;

   logic        item_kind_ff;
   logic [15:0] item_count_ff;

   logic [15:0] res_delay_ff, res_delay_in;
   logic        res_last_ff, res_last_in;
   logic        res_error_ff, res_error_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_delay_ff;
   logic        rsp_last_ff;
   logic        rsp_error_ff;

   srdg_pkg::div_req_type div_req;
   srdg_pkg::div_res_type div_res;

   logic                          req_fire;
   logic [16:0]                   cruise_end;
   logic [srdg_pkg::DivWidth:0]   accel_diff;
   logic [srdg_pkg::DivWidth:0]   decel_sum;
   logic                          rsp_free;

   srdg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   assign req_bus.ready = (state_ff == srdg_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_free      = ~rsp_valid_ff | rsp_bus.ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= srdg_pkg::FIRST_DELAY_RESET;
         min_delay_ff   <= srdg_pkg::MIN_DELAY_RESET;
         k_offset_ff    <= srdg_pkg::K_OFFSET_RESET;
      end else if (csr_bus.valid) begin
         unique case (srdg_pkg::csr_index_type'(csr_bus.index))
            srdg_pkg::CSR_FIRST_DELAY: first_delay_ff <= csr_bus.data;
            srdg_pkg::CSR_MIN_DELAY:   min_delay_ff   <= csr_bus.data;
            srdg_pkg::CSR_K_OFFSET:    k_offset_ff    <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_index_in  = step_index_ff;
      total_steps_in = total_steps_ff;
      prev_delay_in  = prev_delay_ff;
      rem_acc_in     = rem_acc_ff;
      accel_end_in   = accel_end_ff;
      cruise_len_in  = cruise_len_ff;
      move_active_in = move_active_ff;
      decel_in       = decel_ff;
      res_delay_in   = res_delay_ff;
      res_last_in    = res_last_ff;
      res_error_in   = res_error_ff;
      rsp_valid_in   = rsp_valid_ff;

      cruise_end  = {1'b0, accel_end_ff} + {1'b0, cruise_len_ff};
      accel_diff  = {4'b0000, prev_delay_ff} - {1'b0, div_res.quo};
      decel_sum   = {4'b0000, prev_delay_ff} + {1'b0, div_res.quo};

      div_req.start = 1'b0;
      // numerator 2d + r, divisor 4i + 1 + k
      div_req.num = {2'b00, prev_delay_ff, 1'b0} + {1'b0, rem_acc_ff};
      div_req.den = {1'b0, step_index_ff, 2'b00} + {3'b000, k_offset_ff}
                    + srdg_pkg::DivWidth'(1);

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         srdg_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = srdg_pkg::ST_EVAL;
            end
         end

         srdg_pkg::ST_EVAL: begin
            res_delay_in = '0;
            res_last_in  = 1'b0;
            res_error_in = 1'b0;
            state_in     = srdg_pkg::ST_OUT;
            if (item_kind_ff == srdg_pkg::KIND_START) begin
               if (item_count_ff > 16'(srdg_pkg::MaxSteps)) begin
                  res_error_in = 1'b1;
               end else if (item_count_ff == '0) begin
                  res_last_in    = 1'b1;
                  move_active_in = 1'b0;
                  step_index_in  = '0;
                  total_steps_in = '0;
               end else begin
                  total_steps_in = item_count_ff;
                  step_index_in  = 16'd1;
                  rem_acc_in     = '0;
                  accel_end_in   = 16'(({1'b0, item_count_ff} + 17'd1) >> 1);
                  cruise_len_in  = '0;
                  prev_delay_in  = first_delay_ff;
                  move_active_in = 1'b1;
                  res_delay_in   = first_delay_ff;
               end
            end else if (!move_active_ff) begin
               res_error_in = 1'b1;
            end else if (step_index_ff >= total_steps_ff) begin
               res_last_in    = 1'b1;
               move_active_in = 1'b0;
            end else if (step_index_ff < accel_end_ff) begin
               div_req.start = 1'b1;
               decel_in      = 1'b0;
               state_in      = srdg_pkg::ST_DIV;
            end else if ({1'b0, step_index_ff} < cruise_end) begin
               res_delay_in  = min_delay_ff;
               prev_delay_in = min_delay_ff;
               step_index_in = step_index_ff + 16'd1;
            end else begin
               div_req.start = 1'b1;
               decel_in      = 1'b1;
               state_in      = srdg_pkg::ST_DIV;
            end
         end

         srdg_pkg::ST_DIV: begin
            if (div_res.done) begin
               rem_acc_in = div_res.rem[srdg_pkg::DivWidth-1]
                            ? '1 : div_res.rem[srdg_pkg::RemWidth-1:0];
               if (!decel_ff) begin
                  // a borrow wraps to a huge delay, which counts as above the minimum
                  if (accel_diff[srdg_pkg::DivWidth] || (accel_diff[15:0] > min_delay_ff)) begin
                     res_delay_in = accel_diff[15:0];
                  end else begin
                     cruise_len_in = total_steps_ff - {step_index_ff[14:0], 1'b0};
                     accel_end_in  = step_index_ff;
                     res_delay_in  = min_delay_ff;
                  end
               end else begin
                  res_delay_in = (decel_sum[srdg_pkg::DivWidth:16] != '0)
                                 ? 16'hFFFF : decel_sum[15:0];
               end
               prev_delay_in = res_delay_in;
               step_index_in = step_index_ff + 16'd1;
               state_in      = srdg_pkg::ST_OUT;
            end
         end

         srdg_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = srdg_pkg::ST_IDLE;
            end
         end

         default: state_in = srdg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= srdg_pkg::ST_IDLE;
         step_index_ff  <= '0;
         total_steps_ff <= '0;
         prev_delay_ff  <= '0;
         rem_acc_ff     <= '0;
         accel_end_ff   <= '0;
         cruise_len_ff  <= '0;
         move_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_index_ff  <= step_index_in;
         total_steps_ff <= total_steps_in;
         prev_delay_ff  <= prev_delay_in;
         rem_acc_ff     <= rem_acc_in;
         accel_end_ff   <= accel_end_in;
         cruise_len_ff  <= cruise_len_in;
         move_active_ff <= move_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      decel_ff     <= decel_in;
      res_delay_ff <= res_delay_in;
      res_last_ff  <= res_last_in;
      res_error_ff <= res_error_in;
      if (req_fire) begin
         item_kind_ff  <= req_bus.kind;
         item_count_ff <= req_bus.step_count;
      end
      if (state_ff == srdg_pkg::ST_OUT && rsp_free) begin
         rsp_delay_ff <= res_delay_ff;
         rsp_last_ff  <= res_last_ff;
         rsp_error_ff <= res_error_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.delay = rsp_delay_ff;
   assign rsp_bus.last  = rsp_last_ff;
   assign rsp_bus.error = rsp_error_ff;

endmodule

>>> dv/stepper_ramp_delay_generator_unit_tb.sv
// self-checking testbench of the stepper ramp delay generator unit
module stepper_ramp_delay_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ResetCycles   = 10;
   localparam int DrainCycles   = 40;
   localparam int RspHoldCycles = 400;
   localparam int IdleLimit     = 5000;
   localparam int PhaseCount    = 10;
   localparam int PhaseItems    = 140;
   localparam int DirRows       = 24;
   localparam int MaxShown      = 10;
   localparam int unsigned RemSat = 32'h3FFFF;

   typedef struct packed {
      logic [15:0] delay;
      logic        last;
      logic        error;
   } ramp_result_type;

   typedef struct packed {
      logic            kind;
      logic [15:0]     count;
      logic            pinned;
      ramp_result_type res;
   } ramp_vector_type;

   localparam ramp_result_type NoRes     = '0;
   localparam ramp_result_type RejectRes = '{16'd0, 1'b0, 1'b1};
   localparam ramp_result_type EndRes    = '{16'd0, 1'b1, 1'b0};
   localparam ramp_result_type StartRes  = '{srdg_pkg::FIRST_DELAY_RESET, 1'b0, 1'b0};

   // pinned rows assume the register values after reset
   localparam ramp_vector_type DirectedVectors [DirRows] = '{
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b1, RejectRes},  // next while idle
      '{srdg_pkg::KIND_NEXT,  16'hFFFF, 1'b1, RejectRes},
      '{srdg_pkg::KIND_START, 16'd1024, 1'b1, RejectRes},  // one past the step limit
      '{srdg_pkg::KIND_START, 16'hFFFF, 1'b1, RejectRes},
      '{srdg_pkg::KIND_START, 16'h8000, 1'b1, RejectRes},
      '{srdg_pkg::KIND_START, 16'd0,    1'b1, EndRes},     // empty move
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b1, RejectRes},
      '{srdg_pkg::KIND_START, 16'd1,    1'b1, StartRes},
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b1, EndRes},
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b1, RejectRes},
      '{srdg_pkg::KIND_START, 16'd1023, 1'b1, StartRes},   // longest legal move
      '{srdg_pkg::KIND_NEXT,  16'h5555, 1'b0, NoRes},
      '{srdg_pkg::KIND_NEXT,  16'hAAAA, 1'b0, NoRes},
      '{srdg_pkg::KIND_NEXT,  16'h00FF, 1'b0, NoRes},
      '{srdg_pkg::KIND_START, 16'd1024, 1'b1, RejectRes},  // rejected start keeps the move
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b0, NoRes},
      '{srdg_pkg::KIND_START, 16'd3,    1'b1, StartRes},   // replaces the running move
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b0, NoRes},
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b0, NoRes},
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b1, EndRes},
      '{srdg_pkg::KIND_START, 16'd2,    1'b1, StartRes},
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b0, NoRes},
      '{srdg_pkg::KIND_NEXT,  16'h0000, 1'b1, EndRes},
      '{srdg_pkg::KIND_START, 16'd0,    1'b1, EndRes}
   };

   logic clock = 1'b0;
   logic reset;

   srdg_req_if req_bus ();
   srdg_rsp_if rsp_bus ();
   srdg_csr_if csr_bus ();

   stepper_ramp_delay_generator_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   // register copies and move state of the predictor
   logic [15:0] reg_first;
   logic [15:0] reg_min;
   logic [15:0] reg_koff;
   logic [15:0] mv_index;
   logic [15:0] mv_total;
   logic [15:0] mv_prev;
   logic [17:0] mv_rem;
   logic [15:0] mv_accel_end;
   logic [15:0] mv_cruise;
   logic        mv_active;

   ramp_result_type pending_delays [$];
   int mismatch_count = 0;
   int items_sent = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   bit rsp_hold_req = 1'b0;

   function automatic int gap_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 4);
   endfunction

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MaxShown) $display("%0t mismatch: %s", $realtime, msg);
   endfunction

   // one ramp division, carrying the remainder into the next step
   function automatic int unsigned ramp_quotient(input int unsigned i);
      int unsigned den;
      int unsigned num;
      int unsigned r;
      den = 4 * i + 1 + reg_koff;
      num = 2 * mv_prev + mv_rem;
      r = num % den;
      mv_rem = (r > RemSat) ? RemSat[17:0] : r[17:0];
      return num / den;
   endfunction

   function automatic ramp_result_type ramp_next(input logic kind, input logic [15:0] count);
      ramp_result_type res;
      int unsigned i;
      int unsigned t;
      int unsigned s;
      res = '0;
      if (kind == srdg_pkg::KIND_START) begin
         if (count > srdg_pkg::MaxSteps) begin
            res.error = 1'b1;
         end else if (count == 16'd0) begin
            res.last = 1'b1;
            mv_active = 1'b0;
            mv_index = '0;
            mv_total = '0;
         end else begin
            mv_total = count;
            mv_index = 16'd1;
            mv_rem = '0;
            mv_accel_end = 16'((int'(count) + 1) >> 1);
            mv_cruise = '0;
            mv_prev = reg_first;
            mv_active = 1'b1;
            res.delay = reg_first;
         end
      end else if (!mv_active) begin
         res.error = 1'b1;
      end else begin
         i = mv_index;
         if (i >= mv_total) begin
            res.last = 1'b1;
            mv_active = 1'b0;
         end else begin
            if (i < mv_accel_end) begin
               t = mv_prev - ramp_quotient(i);
               if (t > reg_min) begin
                  res.delay = t[15:0];
               end else begin
                  // speed limit reached: cruise so that the ramp down mirrors the ramp up
                  mv_cruise = 16'(int'(mv_total) - 2 * int'(i));
                  mv_accel_end = i[15:0];
                  res.delay = reg_min;
               end
            end else if (i < int'(mv_accel_end) + int'(mv_cruise)) begin
               res.delay = reg_min;
            end else begin
               s = mv_prev + ramp_quotient(i);
               res.delay = (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
            end
            mv_prev = res.delay;
            mv_index = 16'(i + 1);
         end
      end
      return res;
   endfunction

   // valid stays high after a transaction when the next one follows at once
   task automatic push_req(input logic kind, input logic [15:0] count, input logic pinned,
                           input ramp_result_type pinned_res);
      int gap;
      ramp_result_type res;
      gap = 0;
      if (!req_quiet && $urandom_range(0, 2) == 0) gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.step_count <= count;
      do @(posedge clock); while (!req_bus.ready);
      res = ramp_next(kind, count);
      pending_delays.push_back(pinned ? pinned_res : res);
      items_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_delays.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] fd, input logic [15:0] md, input logic [15:0] ko);
      srdg_pkg::csr_index_type idx [3];
      logic [15:0] val [3];
      idx = '{srdg_pkg::CSR_FIRST_DELAY, srdg_pkg::CSR_MIN_DELAY, srdg_pkg::CSR_K_OFFSET};
      val = '{fd, md, ko};
      for (int n = 0; n < 3; n++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[n];
         csr_bus.data <= val[n];
         do @(posedge clock); while (!csr_bus.ready);
         case (idx[n])
            srdg_pkg::CSR_FIRST_DELAY: reg_first = val[n];
            srdg_pkg::CSR_MIN_DELAY:   reg_min = val[n];
            srdg_pkg::CSR_K_OFFSET:    reg_koff = val[n];
            default: ;
         endcase
      end
      csr_bus.valid <= 1'b0;
   endtask

   // result side ready: random stalls, quiet stretches and one long hold-off
   initial begin : rsp_ready_gen
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RspHoldCycles) @(posedge clock);
         end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      ramp_result_type want;
      ramp_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.delay, rsp_bus.last, rsp_bus.error};
         if (pending_delays.size() == 0) begin
            flag_error($sformatf("unexpected result delay=%0d last=%b error=%b",
                                 got.delay, got.last, got.error));
         end else begin
            want = pending_delays.pop_front();
            if (got.delay !== want.delay || got.last !== want.last ||
                got.error !== want.error)
               flag_error($sformatf("delay %0d/%0d last %b/%b error %b/%b (expected/actual)",
                                    want.delay, got.delay, want.last, got.last,
                                    want.error, got.error));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase_start;
      int pick;
      int n;
      int steps;
      logic [15:0] fd;
      logic [15:0] md;
      logic [15:0] ko;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind <= srdg_pkg::KIND_START;
      req_bus.step_count <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= srdg_pkg::CSR_FIRST_DELAY;
      csr_bus.data <= '0;

      reg_first = srdg_pkg::FIRST_DELAY_RESET;
      reg_min = srdg_pkg::MIN_DELAY_RESET;
      reg_koff = srdg_pkg::K_OFFSET_RESET;
      mv_index = '0;
      mv_total = '0;
      mv_prev = '0;
      mv_rem = '0;
      mv_accel_end = '0;
      mv_cruise = '0;
      mv_active = 1'b0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedVectors[r])
         push_req(DirectedVectors[r].kind, DirectedVectors[r].count,
                  DirectedVectors[r].pinned, DirectedVectors[r].res);
      drain();

      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin fd = 16'hFFFF; md = 16'hFFFF; ko = 16'hFFFF; end
            1: begin fd = 16'd1; md = 16'd1; ko = 16'd0; end
            2: begin fd = 16'hFFFF; md = 16'd1; ko = 16'd0; end
            3: begin fd = 16'd0; md = 16'd0; ko = 16'd0; end  // zero delays taken as given
            default: begin
               fd = 16'($urandom_range(1, 65535));
               md = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                : 16'($urandom_range(1, fd));
               ko = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 64));
            end
         endcase
         set_config(fd, md, ko);
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);

         if (p == 4) begin
            // receiver holds off while a full move is offered back to back
            rsp_hold_req = 1'b1;
            req_quiet = 1'b1;
            push_req(srdg_pkg::KIND_START, 16'd40, 1'b0, NoRes);
            repeat (41) push_req(srdg_pkg::KIND_NEXT, 16'($urandom), 1'b0, NoRes);
            req_quiet = 1'b0;
         end

         phase_start = items_sent;
         while (items_sent - phase_start < PhaseItems) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
               // now and then the move is cut short by the next start
               steps = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n) : n + 1;
               push_req(srdg_pkg::KIND_START, 16'(n), 1'b0, NoRes);
               repeat (steps) push_req(srdg_pkg::KIND_NEXT, 16'($urandom), 1'b0, NoRes);
            end else if (pick < 88) begin
               push_req(srdg_pkg::KIND_NEXT, 16'($urandom), 1'b0, NoRes);
            end else if (pick < 95) begin
               push_req(srdg_pkg::KIND_START,
                        16'($urandom_range(srdg_pkg::MaxSteps + 1, 65535)), 1'b0, NoRes);
            end else begin
               push_req(srdg_pkg::KIND_START, 16'd0, 1'b0, NoRes);
            end
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
